FILE: rtl/pva_pkg.sv
// ============================================================================
// pva_pkg: shared types and constants of the priority voice allocator
// Word formats, command codes and the control/status bundles that join the
// controller and the datapath.
// ============================================================================
package pva_pkg;

    localparam int OP_W    = 3;
    localparam int PRIO_W  = 16;
    localparam int ID_W    = 16;
    localparam int CHSEL_W = 4;
    localparam int SAMP_W  = 24;

    // command codes
    localparam logic [OP_W-1:0] OP_ALLOC  = 3'd0;
    localparam logic [OP_W-1:0] OP_STOP   = 3'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 3'd2;
    localparam logic [OP_W-1:0] OP_REPORT = 3'd3;
    localparam logic [OP_W-1:0] OP_FINISH = 3'd4;

    // reset value of the first allocatable channel
    localparam logic [CHSEL_W-1:0] FVC_RESET = 4'd2;

    typedef struct packed {
        logic [OP_W-1:0]          cmd;
        logic signed [PRIO_W-1:0] req_priority;
        logic [ID_W-1:0]          sound_id;
        logic [CHSEL_W-1:0]       channel_sel;
        logic [SAMP_W-1:0]        sample_count;
    } req_word_t;

    typedef struct packed {
        logic [ID_W-1:0]    result_id;
        logic [CHSEL_W-1:0] result_channel;
        logic               playing;
    } rsp_word_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic scan_init;
        logic free_step;
        logic steal_rd;
        logic commit;
        logic mod_start;
        logic lookup_rd;
        logic lookup_done;
        logic sel_done;
        logic none_done;
    } dp_ctl_t;

    // datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            no_window;
        logic            free_hit;
        logic            scan_last;
        logic            mod_done;
    } dp_stat_t;

endpackage

FILE: rtl/pva_rem.sv
// ============================================================================
// pva_rem: remainder by a constant
// Remainder of a 16-bit id by DIVISOR through a scaled reciprocal multiply
// and one correction step; done rises once the corrected remainder is registered.
// ============================================================================
module pva_rem #(
    parameter int DIVISOR = 16,
    localparam int RW     = $clog2(DIVISOR) + 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pva_pkg::ID_W-1:0]   dividend,
    output logic                       done,
    output logic [RW-1:0]              rem
);

    // reciprocal scaled so the quotient estimate is exact or one short
    localparam int SH = pva_pkg::ID_W + $clog2(DIVISOR);
    localparam int MW = pva_pkg::ID_W + 1;
    localparam int PW = pva_pkg::ID_W + MW;
    localparam logic [MW-1:0] RECIP = MW'((64'd1 << SH) / DIVISOR);

    logic [1:0]                 cnt_reg;
    logic [1:0]                 cnt_next;
    logic [pva_pkg::ID_W-1:0]   div_reg;
    logic [pva_pkg::ID_W-1:0]   div_next;
    logic [PW-1:0]              prod_reg;
    logic [PW-1:0]              prod_next;
    logic [pva_pkg::ID_W-1:0]   quot;
    logic [RW-1:0]              rem_reg;
    logic [RW-1:0]              rem_next;

    assign quot = pva_pkg::ID_W'(prod_reg >> SH);

    always_comb
    begin
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        prod_next = prod_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            cnt_next  = 2'd2;
            div_next  = dividend;
            prod_next = PW'(dividend) * PW'(RECIP);
        end
        else if (cnt_reg == 2'd2)
        begin
            // below twice the divisor
            cnt_next = 2'd1;
            rem_next = RW'(div_reg - pva_pkg::ID_W'(quot * pva_pkg::ID_W'(DIVISOR)));
        end
        else if (cnt_reg == 2'd1)
        begin
            cnt_next = 2'd0;
            rem_next = (rem_reg >= RW'(DIVISOR)) ? rem_reg - RW'(DIVISOR) : rem_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rem_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg  <= div_next;
        prod_reg <= prod_next;
    end

    assign done = (cnt_reg == '0);
    assign rem  = rem_reg;

`ifndef SYNTHESIS
    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (rem_reg < RW'(DIVISOR)))
        else $error("remainder not below divisor");
`endif

endmodule

FILE: rtl/pva_dp.sv
// ============================================================================
// pva_dp: voice allocator datapath
// Channel tables, busy bits, scan counter, best-candidate tracking,
// generation counter, config register and result register.
// ============================================================================
module pva_dp #(
    parameter int CHANNELS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pva_pkg::req_word_t            req,
    input  logic                          cfg_wr,
    input  logic [pva_pkg::CHSEL_W-1:0]   cfg_wdata,
    input  pva_pkg::dp_ctl_t              ctl,
    output pva_pkg::dp_stat_t             stat,
    output pva_pkg::rsp_word_t            rsp
);

    localparam int CH_W  = $clog2(CHANNELS);
    localparam int CMP_W = (CH_W + 1 > pva_pkg::CHSEL_W) ? CH_W + 1 : pva_pkg::CHSEL_W;

    // config and captured request
    logic [pva_pkg::CHSEL_W-1:0] fvc_reg;
    pva_pkg::req_word_t          in_reg;

    // tables
    logic [pva_pkg::ID_W-1:0]          id_mem   [CHANNELS];
    logic signed [pva_pkg::PRIO_W-1:0] prio_mem [CHANNELS];
    logic [pva_pkg::SAMP_W-1:0]        samp_mem [CHANNELS];
    logic [pva_pkg::ID_W-1:0]          id_rd;
    logic signed [pva_pkg::PRIO_W-1:0] prio_rd;
    logic [pva_pkg::SAMP_W-1:0]        samp_rd;
    logic [CH_W-1:0]                   rd_addr;
    logic [CHANNELS-1:0]               busy_reg;

    // scan and candidate
    logic [CH_W-1:0]                   scan_reg;
    logic                              rd_vld_reg;
    logic [CH_W-1:0]                   rd_idx_reg;
    logic                              best_vld_reg;
    logic [CH_W-1:0]                   best_idx_reg;
    logic signed [pva_pkg::PRIO_W-1:0] best_prio_reg;
    logic [pva_pkg::SAMP_W-1:0]        best_samp_reg;
    logic                              cand;
    logic                              better;

    // generation
    logic [pva_pkg::ID_W-1:0] gen_reg;
    logic [pva_pkg::ID_W-1:0] gen_next;
    logic [pva_pkg::ID_W-1:0] gen_step;
    logic [pva_pkg::ID_W-1:0] new_id;
    logic                     alloc_we;

    // lookups
    logic                     rem_done;
    logic [CH_W:0]            rem;
    logic [CH_W-1:0]          rem_idx;
    logic                     match;
    logic                     sel_ok;
    logic [CH_W-1:0]          sel_idx;
    logic                     report_we;
    logic                     stop_clr;
    logic                     finish_clr;

    pva_rem #(
        .DIVISOR (CHANNELS)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.mod_start),
        .dividend (in_reg.sound_id),
        .done     (rem_done),
        .rem      (rem)
    );

    assign rem_idx = rem[CH_W-1:0];
    assign sel_idx = CH_W'(in_reg.channel_sel);
    assign sel_ok  = CMP_W'(in_reg.channel_sel) < CMP_W'(CHANNELS);

    // status
    assign stat.op        = in_reg.cmd;
    assign stat.no_window = CMP_W'(fvc_reg) >= CMP_W'(CHANNELS);
    assign stat.free_hit  = !busy_reg[scan_reg];
    assign stat.scan_last = (scan_reg == CH_W'(CHANNELS - 1));
    assign stat.mod_done  = rem_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fvc_reg <= pva_pkg::FVC_RESET;
        end
        else if (cfg_wr)
        begin
            fvc_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            in_reg <= req;
        end
    end

    // table read port: scan address or id lookup
    assign rd_addr = ctl.lookup_rd ? rem_idx : scan_reg;

    assign gen_step  = pva_pkg::ID_W'(CHANNELS);
    assign new_id    = gen_reg + pva_pkg::ID_W'(best_idx_reg);
    assign alloc_we  = ctl.commit && best_vld_reg && (new_id != '0);
    assign report_we = ctl.sel_done && (in_reg.cmd == pva_pkg::OP_REPORT) && sel_ok;
    assign match     = (in_reg.sound_id != '0) && busy_reg[rem_idx] && (id_rd == in_reg.sound_id);
    assign stop_clr  = ctl.lookup_done && (in_reg.cmd == pva_pkg::OP_STOP) && match;
    assign finish_clr = ctl.sel_done && (in_reg.cmd == pva_pkg::OP_FINISH) && sel_ok;

    always_ff @(posedge clk)
    begin
        id_rd   <= id_mem[rd_addr];
        prio_rd <= prio_mem[rd_addr];
        samp_rd <= samp_mem[rd_addr];
        if (alloc_we)
        begin
            id_mem[best_idx_reg]   <= new_id;
            prio_mem[best_idx_reg] <= in_reg.req_priority;
        end
        if (alloc_we || report_we)
        begin
            samp_mem[alloc_we ? best_idx_reg : sel_idx] <= in_reg.sample_count;
        end
    end

    // busy bits stand for a nonzero id
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
        end
        else
        begin
            if (alloc_we)
            begin
                busy_reg[best_idx_reg] <= 1'b1;
            end
            if (stop_clr)
            begin
                busy_reg[rem_idx] <= 1'b0;
            end
            if (finish_clr)
            begin
                busy_reg[sel_idx] <= 1'b0;
            end
        end
    end

    // steal compare: lowest priority at or below request, then fewest samples
    assign cand   = (prio_rd <= in_reg.req_priority);
    assign better = !best_vld_reg || (prio_rd < best_prio_reg) ||
                    ((prio_rd == best_prio_reg) && (samp_rd < best_samp_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg   <= 1'b0;
            best_vld_reg <= 1'b0;
            scan_reg     <= '0;
        end
        else
        begin
            rd_vld_reg <= ctl.steal_rd;
            if (ctl.accept)
            begin
                best_vld_reg <= 1'b0;
            end
            else if (ctl.free_step && stat.free_hit)
            begin
                best_vld_reg <= 1'b1;
            end
            else if (rd_vld_reg && cand && better)
            begin
                best_vld_reg <= 1'b1;
            end

            if (ctl.scan_init)
            begin
                scan_reg <= CH_W'(fvc_reg);
            end
            else if (ctl.free_step || ctl.steal_rd)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= scan_reg;
        if (ctl.free_step && stat.free_hit)
        begin
            best_idx_reg <= scan_reg;
        end
        else if (rd_vld_reg && cand && better)
        begin
            best_idx_reg  <= rd_idx_reg;
            best_prio_reg <= prio_rd;
            best_samp_reg <= samp_rd;
        end
    end

    // generation steps by the channel count and skips zero
    always_comb
    begin
        gen_next = gen_reg;
        if (ctl.commit && best_vld_reg)
        begin
            gen_next = gen_reg + gen_step;
            if (gen_next == '0)
            begin
                gen_next = gen_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg <= pva_pkg::ID_W'(CHANNELS);
        end
        else
        begin
            gen_reg <= gen_next;
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            rsp.result_id      <= alloc_we ? new_id : '0;
            rsp.result_channel <= alloc_we ? pva_pkg::CHSEL_W'(best_idx_reg) : '0;
            rsp.playing        <= 1'b0;
        end
        else if (ctl.lookup_done)
        begin
            rsp.result_id      <= '0;
            rsp.result_channel <= pva_pkg::CHSEL_W'(rem_idx);
            rsp.playing        <= match;
        end
        else if (ctl.sel_done)
        begin
            rsp.result_id      <= '0;
            rsp.result_channel <= in_reg.channel_sel;
            rsp.playing        <= sel_ok && busy_reg[sel_idx];
        end
        else if (ctl.none_done)
        begin
            rsp <= '0;
        end
    end

`ifndef SYNTHESIS
    a_pick_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.commit && best_vld_reg) |-> (CMP_W'(best_idx_reg) >= CMP_W'(fvc_reg)))
        else $error("allocated channel below first voice channel");
    a_stop_frees: assert property (@(posedge clk) disable iff (!rst_n)
        stop_clr |=> !busy_reg[$past(rem_idx)])
        else $error("stopped channel still busy");
`endif

endmodule

FILE: rtl/pva_ctrl.sv
// ============================================================================
// pva_ctrl: voice allocator controller
// One-hot sequencer that steps the datapath through each command and
// raises the done strobe with the result word.
// ============================================================================
module pva_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    input  pva_pkg::dp_stat_t  stat,
    output pva_pkg::dp_ctl_t   ctl
);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_DISPATCH  = 9'b000000010,
        S_FREE      = 9'b000000100,
        S_STEAL     = 9'b000001000,
        S_STEAL_END = 9'b000010000,
        S_COMMIT    = 9'b000100000,
        S_MOD       = 9'b001000000,
        S_LOOK      = 9'b010000000,
        S_CHECK     = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.accept = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (stat.op) inside
                    pva_pkg::OP_ALLOC:
                    begin
                        if (stat.no_window)
                        begin
                            state_next = S_COMMIT;
                        end
                        else
                        begin
                            ctl.scan_init = 1'b1;
                            state_next    = S_FREE;
                        end
                    end
                    pva_pkg::OP_STOP, pva_pkg::OP_QUERY:
                    begin
                        ctl.mod_start = 1'b1;
                        state_next    = S_MOD;
                    end
                    pva_pkg::OP_REPORT, pva_pkg::OP_FINISH:
                    begin
                        ctl.sel_done = 1'b1;
                        state_next   = S_IDLE;
                    end
                    default:
                    begin
                        ctl.none_done = 1'b1;
                        state_next    = S_IDLE;
                    end
                endcase
            end
            S_FREE:
            begin
                ctl.free_step = 1'b1;
                if (stat.free_hit)
                begin
                    state_next = S_COMMIT;
                end
                else if (stat.scan_last)
                begin
                    ctl.free_step = 1'b0;
                    ctl.scan_init = 1'b1;
                    state_next    = S_STEAL;
                end
            end
            S_STEAL:
            begin
                ctl.steal_rd = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_STEAL_END;
                end
            end
            S_STEAL_END:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                ctl.commit = 1'b1;
                state_next = S_IDLE;
            end
            S_MOD:
            begin
                if (stat.mod_done)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                ctl.lookup_rd = 1'b1;
                state_next    = S_CHECK;
            end
            S_CHECK:
            begin
                ctl.lookup_done = 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign done_next = ctl.commit || ctl.lookup_done || ctl.sel_done || ctl.none_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

`ifndef SYNTHESIS
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) != S_IDLE))
        else $error("done strobe without a command in flight");
    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (start && (state_reg == S_IDLE)) |=> (state_reg == S_DISPATCH))
        else $error("accepted word not dispatched");
`endif

endmodule

FILE: rtl/priority_voice_allocator_top.sv
// ============================================================================
// priority_voice_allocator_top: voice allocator with priority stealing
// Allocates, stops, queries and retires sound voices over a channel table.
// ============================================================================
// usage
//   command channel: drive a word on req and raise start; the word is taken
//   at a rising edge with start high and busy low. busy stays high until the
//   result word has been loaded.
//   result channel: rsp carries the result word, marked by done, which is
//   high for exactly one cycle; the receiver cannot stall it, so it must
//   sample rsp when done is high. every command gives exactly one result word.
//   config: cfg_wr with cfg_wdata sets the first allocatable channel; write
//   only while busy is low and no done strobe is pending.
// steps, accepting edge to the edge that raises done
//   report, finish, unknown command: the result word is loaded at dispatch
//   stop, query: dispatch, wait on the id-to-channel remainder, read, check
//   allocate, free channel found: dispatch, free scan up to it, commit
//   allocate with stealing: dispatch, free scan, steal scan, steal end and
//   commit; one channel per cycle through the free scan and again through
//   the table read port for the steal compare
// throughput: one command at a time; the next may start in the done cycle
// reset: all channels free, generation at CHANNELS, first channel 2
// ============================================================================
module priority_voice_allocator_top #(
    parameter int CHANNELS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  pva_pkg::req_word_t            req,
    output logic                          done,
    output pva_pkg::rsp_word_t            rsp,
    input  logic                          cfg_wr,
    input  logic [pva_pkg::CHSEL_W-1:0]   cfg_wdata
);

    // command and status between sequencer and datapath
    pva_pkg::dp_ctl_t  ctl;
    pva_pkg::dp_stat_t stat;

    // sequencer: one command at a time
    pva_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .stat  (stat),
        .ctl   (ctl)
    );

    // channel tables, scan, generation and result word
    pva_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_wr    (cfg_wr),
        .cfg_wdata (cfg_wdata),
        .ctl       (ctl),
        .stat      (stat),
        .rsp       (rsp)
    );

endmodule
